### hw/rtl/v3au_pkg.sv
// shared types, operation codes and the round/saturate helper
// for the three-component vector unit; no dependencies
`default_nettype none

package v3au_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD   = 4'd0,
        FUNC_SUB   = 4'd1,
        FUNC_SCALE = 4'd2,
        FUNC_DIV   = 4'd3,
        FUNC_DOT   = 4'd4,
        FUNC_CROSS = 4'd5,
        FUNC_LSQ   = 4'd6,
        FUNC_LEN   = 4'd7,
        FUNC_NORM  = 4'd8
    } t_func;

    // request data that rides alongside the root and reciprocal units
    typedef struct packed {
        t_func              func;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] rs;
        logic               sat;
        logic               sneg;
        logic [31:0]        smag;
    } t_side;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_rsat;

    // round half toward plus infinity to frac fraction bits, clip to 32 bits
    function automatic t_rsat f_round_sat(input logic signed [66:0] e, input int frac);
        logic signed [66:0] t;
        t_rsat              r;
        t = (e + (67'sd1 <<< (frac - 1))) >>> frac;
        r.sat = (t[66:31] != {36{t[66]}});
        if (r.sat) begin
            r.val = t[66] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r.val = t[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/v3au_front.sv
// front end: input register, products, sums and the direct results
// depends on v3au_pkg
`default_nettype none

module v3au_front import v3au_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_scale_value,
    output logic                    o_vld,
    output t_side                   o_side,
    output logic [63:0]             o_sq
);

    // stage 0: input register
    logic               r0_vld;
    t_func              r0_func;
    logic signed [31:0] r0_a [3];
    logic signed [31:0] r0_b [3];
    logic signed [31:0] r0_s;

    // stage 1: products and add/sub
    logic               r1_vld;
    t_func              r1_func;
    logic signed [63:0] r1_p [6];
    logic signed [31:0] r1_as [3];
    logic [2:0]         r1_as_sat;
    logic signed [31:0] r1_a [3];
    logic               r1_sneg;
    logic [31:0]        r1_smag;

    // stage 2: sums
    logic               r2_vld;
    t_func              r2_func;
    logic signed [65:0] r2_e [3];
    logic signed [31:0] r2_as [3];
    logic [2:0]         r2_as_sat;
    logic signed [31:0] r2_a [3];
    logic               r2_sneg;
    logic [31:0]        r2_smag;

    // stage 3: rounded results
    logic               r3_vld;
    t_side              r3_side;
    logic [63:0]        r3_sq;

    logic signed [31:0] w_lhs [3];
    logic signed [31:0] w_rhs [3];
    logic signed [63:0] n1_p [6];
    logic signed [32:0] w_sum [3];
    logic signed [31:0] n1_as [3];
    logic [2:0]         n1_as_sat;
    logic signed [65:0] w_pe [6];
    logic signed [65:0] n2_e [3];
    t_rsat              w_rnd [3];
    t_side              n3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_func <= t_func'(i_func);
        r0_a[0] <= i_a_x;
        r0_a[1] <= i_a_y;
        r0_a[2] <= i_a_z;
        r0_b[0] <= i_b_x;
        r0_b[1] <= i_b_y;
        r0_b[2] <= i_b_z;
        r0_s    <= i_scale_value;
    end

    // operand selection for the three shared multipliers
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lhs[i] = r0_a[i];
            w_rhs[i] = r0_s;
        end
        unique case (r0_func)
            FUNC_CROSS: begin
                w_lhs[0] = r0_a[1];
                w_lhs[1] = r0_a[2];
                w_lhs[2] = r0_a[0];
                w_rhs[0] = r0_b[2];
                w_rhs[1] = r0_b[0];
                w_rhs[2] = r0_b[1];
            end
            FUNC_DOT: begin
                for (int i = 0; i < 3; i++) w_rhs[i] = r0_b[i];
            end
            FUNC_LSQ, FUNC_LEN, FUNC_NORM: begin
                for (int i = 0; i < 3; i++) w_rhs[i] = r0_a[i];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_p[i] = w_lhs[i] * w_rhs[i];
        end
        // second halves of the cross terms
        n1_p[3] = r0_a[2] * r0_b[1];
        n1_p[4] = r0_a[0] * r0_b[2];
        n1_p[5] = r0_a[1] * r0_b[0];
        for (int i = 0; i < 3; i++) begin
            if (r0_func == FUNC_SUB) begin
                w_sum[i] = 33'(r0_a[i]) - 33'(r0_b[i]);
            end else begin
                w_sum[i] = 33'(r0_a[i]) + 33'(r0_b[i]);
            end
            n1_as_sat[i] = (w_sum[i][32] != w_sum[i][31]);
            if (n1_as_sat[i]) begin
                n1_as[i] = w_sum[i][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                n1_as[i] = w_sum[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_func   <= r0_func;
        r1_p      <= n1_p;
        r1_as     <= n1_as;
        r1_as_sat <= n1_as_sat;
        r1_a      <= r0_a;
        r1_sneg   <= r0_s[31];
        r1_smag   <= r0_s[31] ? 32'(-r0_s) : 32'(r0_s);
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_pe[i] = 66'(r1_p[i]);
        end
        for (int i = 0; i < 3; i++) begin
            n2_e[i] = w_pe[i];
        end
        unique case (r1_func)
            FUNC_CROSS: begin
                for (int i = 0; i < 3; i++) n2_e[i] = w_pe[i] - w_pe[i + 3];
            end
            FUNC_DOT, FUNC_LSQ, FUNC_LEN, FUNC_NORM: begin
                n2_e[0] = w_pe[0] + w_pe[1] + w_pe[2];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_func   <= r1_func;
        r2_e      <= n2_e;
        r2_as     <= r1_as;
        r2_as_sat <= r1_as_sat;
        r2_a      <= r1_a;
        r2_sneg   <= r1_sneg;
        r2_smag   <= r1_smag;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = f_round_sat(67'(r2_e[i]), FRAC_BITS);
        end
        n3_side.func = r2_func;
        n3_side.rx   = '0;
        n3_side.ry   = '0;
        n3_side.rz   = '0;
        n3_side.rs   = '0;
        n3_side.sat  = 1'b0;
        n3_side.sneg = r2_sneg;
        n3_side.smag = r2_smag;
        unique case (r2_func)
            FUNC_ADD, FUNC_SUB: begin
                n3_side.rx  = r2_as[0];
                n3_side.ry  = r2_as[1];
                n3_side.rz  = r2_as[2];
                n3_side.sat = |r2_as_sat;
            end
            FUNC_SCALE, FUNC_CROSS: begin
                n3_side.rx  = w_rnd[0].val;
                n3_side.ry  = w_rnd[1].val;
                n3_side.rz  = w_rnd[2].val;
                n3_side.sat = w_rnd[0].sat | w_rnd[1].sat | w_rnd[2].sat;
            end
            FUNC_DOT, FUNC_LSQ: begin
                n3_side.rs  = w_rnd[0].val;
                n3_side.sat = w_rnd[0].sat;
            end
            FUNC_DIV, FUNC_NORM: begin
                // a rides in the result slots until the final multiply
                n3_side.rx = r2_a[0];
                n3_side.ry = r2_a[1];
                n3_side.rz = r2_a[2];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_side <= n3_side;
        r3_sq   <= r2_e[0][63:0];
    end

    assign o_vld  = r3_vld;
    assign o_side = r3_side;
    assign o_sq   = r3_sq;

endmodule

`default_nettype wire

### hw/rtl/v3au_sqrt.sv
// pipelined integer square root, one root bit per stage, rounded to nearest
// depends on v3au_pkg
`default_nettype none

module v3au_sqrt import v3au_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire t_side       i_side,
    input  wire logic [63:0] i_sq,
    output logic             o_vld,
    output t_side            o_side,
    output logic [32:0]      o_len
);

    localparam int NS = 32;

    logic        r_vld  [NS];
    t_side       r_side [NS];
    logic [63:0] r_v    [NS];
    logic [33:0] r_rem  [NS];
    logic [31:0] r_root [NS];

    logic        r_out_vld;
    t_side       r_out_side;
    logic [32:0] r_len;

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic        w_vld;
        t_side       w_side;
        logic [63:0] w_v;
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [35:0] w_cat;
        logic [35:0] w_try;
        logic [35:0] w_diff;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_v    = i_sq;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_cat  = {w_rem, w_v[63:62]};
        assign w_try  = {2'b00, w_root, 2'b01};
        assign w_diff = w_cat - w_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            r_v[k]    <= {w_v[61:0], 2'b00};
            if (w_cat >= w_try) begin
                r_rem[k]  <= w_diff[33:0];
                r_root[k] <= {w_root[30:0], 1'b1};
            end else begin
                r_rem[k]  <= w_cat[33:0];
                r_root[k] <= {w_root[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NS-1];
        end
    end

    // round up when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        r_out_side <= r_side[NS-1];
        r_len      <= {1'b0, r_root[NS-1]}
                    + 33'(r_rem[NS-1] > {2'b00, r_root[NS-1]});
    end

    assign o_vld  = r_out_vld;
    assign o_side = r_out_side;
    assign o_len  = r_len;

endmodule

`default_nettype wire

### hw/rtl/v3au_recip.sv
// pipelined restoring divider forming round(2^(2*FRAC_BITS) / d),
// one quotient bit per stage; depends on v3au_pkg
`default_nettype none

module v3au_recip import v3au_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int NW = (2 * FRAC_BITS + 2 > 34) ? 2 * FRAC_BITS + 2 : 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire t_side         i_side,
    input  wire logic [32:0]   i_div,
    output logic               o_vld,
    output t_side              o_side,
    output logic [32:0]        o_div,
    output logic [NW-1:0]      o_quo
);

    logic          r_vld  [NW];
    t_side         r_side [NW];
    logic [32:0]   r_d    [NW];
    logic [NW-1:0] r_n    [NW];
    logic [32:0]   r_rem  [NW];
    logic [NW-1:0] r_q    [NW];

    logic [NW-1:0] w_num;

    // numerator with half the divisor added for round to nearest
    assign w_num = (NW'(1) << (2 * FRAC_BITS)) + NW'(i_div >> 1);

    for (genvar k = 0; k < NW; k++) begin : g_step
        logic          w_vld;
        t_side         w_side;
        logic [32:0]   w_d;
        logic [NW-1:0] w_n;
        logic [32:0]   w_rem;
        logic [NW-1:0] w_q;
        logic [33:0]   w_cat;
        logic [33:0]   w_diff;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_d    = i_div;
            assign w_n    = w_num;
            assign w_rem  = '0;
            assign w_q    = '0;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
            assign w_d    = r_d[k-1];
            assign w_n    = r_n[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_q    = r_q[k-1];
        end

        assign w_cat  = {w_rem, w_n[NW-1]};
        assign w_diff = w_cat - {1'b0, w_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            r_d[k]    <= w_d;
            r_n[k]    <= {w_n[NW-2:0], 1'b0};
            if (w_cat >= {1'b0, w_d}) begin
                r_rem[k] <= w_diff[32:0];
                r_q[k]   <= {w_q[NW-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_cat[32:0];
                r_q[k]   <= {w_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_side = r_side[NW-1];
    assign o_div  = r_d[NW-1];
    assign o_quo  = r_q[NW-1];

endmodule

`default_nettype wire

### hw/rtl/v3au_back.sv
// back end: reciprocal clip, final multiply, rounding and result select
// depends on v3au_pkg
`default_nettype none

module v3au_back import v3au_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int NW = (2 * FRAC_BITS + 2 > 34) ? 2 * FRAC_BITS + 2 : 34
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire t_side              i_side,
    input  wire logic [32:0]        i_div,
    input  wire logic [NW-1:0]      i_quo,
    output logic                    o_valid,
    output logic signed [31:0]      o_res_x,
    output logic signed [31:0]      o_res_y,
    output logic signed [31:0]      o_res_z,
    output logic signed [31:0]      o_res_scalar,
    output logic                    o_passed_through,
    output logic                    o_saturated
);

    logic               r0_vld;
    t_side              r0_side;
    logic signed [31:0] r0_rcp;
    logic               r0_rcp_sat;
    logic               r0_pass;

    logic               r1_vld;
    t_side              r1_side;
    logic               r1_rcp_sat;
    logic               r1_pass;
    logic signed [63:0] r1_p [3];

    logic               r2_vld;
    logic signed [31:0] r2_res [3];
    logic signed [31:0] r2_rs;
    logic               r2_pass;
    logic               r2_sat;

    logic               w_recip_op;
    logic               w_neg;
    logic               n0_rcp_sat;
    logic signed [31:0] n0_rcp;
    t_side              n0_side;
    logic signed [63:0] n1_p [3];
    t_rsat              w_rnd [3];
    logic               w_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_comb begin
        w_recip_op = (i_side.func == FUNC_DIV) || (i_side.func == FUNC_NORM);
        w_neg      = (i_side.func == FUNC_DIV) && i_side.sneg;
        if (w_neg) begin
            n0_rcp_sat = (i_quo[NW-1:32] != '0) || (i_quo[31] && (i_quo[30:0] != '0));
            n0_rcp     = n0_rcp_sat ? 32'sh8000_0000 : 32'(-i_quo[31:0]);
        end else begin
            n0_rcp_sat = (i_quo[NW-1:31] != '0);
            n0_rcp     = n0_rcp_sat ? 32'sh7fff_ffff : 32'(i_quo[31:0]);
        end
        n0_side = i_side;
        // length comes straight from the root, clipped
        if (i_side.func == FUNC_LEN) begin
            if (i_div[32:31] != 2'b00) begin
                n0_side.rs  = 32'sh7fff_ffff;
                n0_side.sat = 1'b1;
            end else begin
                n0_side.rs = 32'(i_div[30:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r0_side    <= n0_side;
        r0_rcp     <= n0_rcp;
        r0_rcp_sat <= n0_rcp_sat;
        r0_pass    <= w_recip_op && (i_div == '0);
    end

    always_comb begin
        n1_p[0] = r0_side.rx * r0_rcp;
        n1_p[1] = r0_side.ry * r0_rcp;
        n1_p[2] = r0_side.rz * r0_rcp;
    end

    always_ff @(posedge i_clk) begin
        r1_side    <= r0_side;
        r1_rcp_sat <= r0_rcp_sat;
        r1_pass    <= r0_pass;
        r1_p       <= n1_p;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = f_round_sat(67'(r1_p[i]), FRAC_BITS);
        end
        w_use = ((r1_side.func == FUNC_DIV) || (r1_side.func == FUNC_NORM)) && !r1_pass;
    end

    always_ff @(posedge i_clk) begin
        r2_rs   <= r1_side.rs;
        r2_pass <= r1_pass;
        if (w_use) begin
            r2_res[0] <= w_rnd[0].val;
            r2_res[1] <= w_rnd[1].val;
            r2_res[2] <= w_rnd[2].val;
            r2_sat    <= r1_side.sat | r1_rcp_sat | w_rnd[0].sat | w_rnd[1].sat
                       | w_rnd[2].sat;
        end else begin
            r2_res[0] <= r1_side.rx;
            r2_res[1] <= r1_side.ry;
            r2_res[2] <= r1_side.rz;
            r2_sat    <= r1_side.sat;
        end
    end

    assign o_valid          = r2_vld;
    assign o_res_x          = r2_res[0];
    assign o_res_y          = r2_res[1];
    assign o_res_z          = r2_res[2];
    assign o_res_scalar     = r2_rs;
    assign o_passed_through = r2_pass;
    assign o_saturated      = r2_sat;

endmodule

`default_nettype wire

### hw/rtl/vector3_arithmetic_unit.sv
// Three-component vector unit, signed fixed point with FRAC_BITS fraction bits.
// A request is taken whenever i_start is high; o_busy is always low, so one request
// may enter every cycle. Each result appears on the o_res_* ports for one cycle with
// o_valid high, in request order. Every request passes through the 33-stage square root
// (32 root bits and a rounding stage) and the NW-stage reciprocal divider, where
// NW = max(2*FRAC_BITS+2, 34), plus four front and three back stages.
// Results cannot be held off.
// top level: v3au_front, v3au_sqrt, v3au_recip, v3au_back; uses v3au_pkg
`default_nettype none

module vector3_arithmetic_unit import v3au_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_scale_value,
    output logic                    o_valid,
    output logic signed [31:0]      o_res_x,
    output logic signed [31:0]      o_res_y,
    output logic signed [31:0]      o_res_z,
    output logic signed [31:0]      o_res_scalar,
    output logic                    o_passed_through,
    output logic                    o_saturated
);

    localparam int NW = (2 * FRAC_BITS + 2 > 34) ? 2 * FRAC_BITS + 2 : 34;

    logic          front_vld;
    t_side         front_side;
    logic [63:0]   front_sq;
    logic          sqrt_vld;
    t_side         sqrt_side;
    logic [32:0]   sqrt_len;
    logic [32:0]   recip_in;
    logic          recip_vld;
    t_side         recip_side;
    logic [32:0]   recip_div;
    logic [NW-1:0] recip_quo;

    assign o_busy = 1'b0;

    v3au_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (i_start && !o_busy),
        .i_func        (i_func),
        .i_a_x         (i_a_x),
        .i_a_y         (i_a_y),
        .i_a_z         (i_a_z),
        .i_b_x         (i_b_x),
        .i_b_y         (i_b_y),
        .i_b_z         (i_b_z),
        .i_scale_value (i_scale_value),
        .o_vld         (front_vld),
        .o_side        (front_side),
        .o_sq          (front_sq)
    );

    v3au_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .i_side  (front_side),
        .i_sq    (front_sq),
        .o_vld   (sqrt_vld),
        .o_side  (sqrt_side),
        .o_len   (sqrt_len)
    );

    // divide uses the scalar magnitude, everything else the length
    assign recip_in = (sqrt_side.func == FUNC_DIV) ? {1'b0, sqrt_side.smag} : sqrt_len;

    v3au_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sqrt_vld),
        .i_side  (sqrt_side),
        .i_div   (recip_in),
        .o_vld   (recip_vld),
        .o_side  (recip_side),
        .o_div   (recip_div),
        .o_quo   (recip_quo)
    );

    v3au_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (recip_vld),
        .i_side           (recip_side),
        .i_div            (recip_div),
        .i_quo            (recip_quo),
        .o_valid          (o_valid),
        .o_res_x          (o_res_x),
        .o_res_y          (o_res_y),
        .o_res_z          (o_res_z),
        .o_res_scalar     (o_res_scalar),
        .o_passed_through (o_passed_through),
        .o_saturated      (o_saturated)
    );

endmodule

`default_nettype wire

### bench/vector3_arithmetic_unit_tb.sv
// testbench for the three-component vector unit: directed and random requests,
// results predicted in the bench and checked field by field; uses v3au_pkg
module vector3_arithmetic_unit_tb;
    import v3au_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] rs;
        logic               pass;
        logic               sat;
    } t_vres;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic [3:0] i_func = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0, i_scale_value = '0;
    logic o_busy, o_valid, o_passed_through, o_saturated;
    logic signed [31:0] o_res_x, o_res_y, o_res_z, o_res_scalar;

    t_vres expected_q[$];
    int    errors = 0;
    int    idle_cycles = 0;

    vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // exact signed arithmetic in 130 bits, then round and clip once
    function automatic logic signed [129:0] rnd(input logic signed [129:0] e);
        logic signed [129:0] h;
        h = 130'sd1 <<< (FRAC - 1);
        return (e + h) >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clip(input logic signed [129:0] v,
                                                inout logic sat);
        if (v > 130'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -130'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] recip_of(input logic [63:0] mag, input logic neg,
                                                    inout logic sat);
        logic [127:0] q;
        q = ((128'd1 << (2 * FRAC)) + mag / 2) / mag;
        if (!neg) begin
            if (q > 128'h7fff_ffff) begin
                sat = 1'b1;
                return 32'sh7fff_ffff;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return -$signed({1'b0, q[31:0]});
    endfunction

    function automatic logic [63:0] root_rounded(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic t_vres predict_vector_op(input logic [3:0] f,
                                                input logic signed [31:0] a[3],
                                                input logic signed [31:0] b[3],
                                                input logic signed [31:0] s);
        t_vres r;
        logic signed [31:0] v[3];
        logic signed [129:0] acc;
        logic signed [31:0] rcp;
        logic [63:0] sq, len;
        int j, k;
        r = '{default: '0};
        v = '{default: '0};
        sq = 0;
        for (int i = 0; i < 3; i++) sq += 64'($signed(a[i]) * $signed(a[i]) < 0 ? 0 : 0)
            + 64'(longint'(a[i]) * longint'(a[i]));
        case (f)
            FUNC_ADD: for (int i = 0; i < 3; i++) v[i] = clip(130'(a[i]) + 130'(b[i]), r.sat);
            FUNC_SUB: for (int i = 0; i < 3; i++) v[i] = clip(130'(a[i]) - 130'(b[i]), r.sat);
            FUNC_SCALE: for (int i = 0; i < 3; i++) v[i] = clip(rnd(130'(a[i]) * 130'(s)), r.sat);
            FUNC_DIV: begin
                if (s == 0) begin
                    r.pass = 1'b1;
                    v = a;
                end else begin
                    rcp = recip_of(s < 0 ? 64'(-longint'(s)) : 64'(s), s < 0, r.sat);
                    for (int i = 0; i < 3; i++) v[i] = clip(rnd(130'(a[i]) * 130'(rcp)), r.sat);
                end
            end
            FUNC_DOT: begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += 130'(a[i]) * 130'(b[i]);
                r.rs = clip(rnd(acc), r.sat);
            end
            FUNC_CROSS: for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                v[i] = clip(rnd(130'(a[j]) * 130'(b[k]) - 130'(a[k]) * 130'(b[j])), r.sat);
            end
            FUNC_LSQ: r.rs = clip(rnd(130'($unsigned(sq))), r.sat);
            FUNC_LEN: begin
                len = root_rounded(sq);
                if (len > 64'h7fff_ffff) begin
                    r.sat = 1'b1;
                    r.rs = 32'sh7fff_ffff;
                end else begin
                    r.rs = len[31:0];
                end
            end
            FUNC_NORM: begin
                if (sq == 0) begin
                    r.pass = 1'b1;
                    v = a;
                end else begin
                    rcp = recip_of(root_rounded(sq), 1'b0, r.sat);
                    for (int i = 0; i < 3; i++) v[i] = clip(rnd(130'(a[i]) * 130'(rcp)), r.sat);
                end
            end
            default: ;
        endcase
        r.rx = v[0];
        r.ry = v[1];
        r.rz = v[2];
        return r;
    endfunction

    task automatic send_request(input logic [3:0] f, input logic signed [31:0] a[3],
                                input logic signed [31:0] b[3], input logic signed [31:0] s,
                                input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_func <= f;
        {i_a_x, i_a_y, i_a_z} <= {a[0], a[1], a[2]};
        {i_b_x, i_b_y, i_b_z} <= {b[0], b[1], b[2]};
        i_scale_value <= s;
        do @(posedge i_clk); while (o_busy);
        expected_q.push_back(predict_vector_op(f, a, b, s));
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return 32'sh0001_0000;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] a[3], b[3], z[3];
        logic signed [31:0] mx, mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        z = '{0, 0, 0};
        a = '{mx, mn, 32'sh0001_8000};
        b = '{mx, mn, -32'sh0000_8000};
        for (int f = 0; f < 16; f++) send_request(f[3:0], a, b, 32'sh0002_0000, 0);
        send_request(FUNC_DIV, a, b, 0, 0);          // zero divisor
        send_request(FUNC_NORM, z, b, 0, 0);         // zero length
        send_request(FUNC_DIV, a, b, 1, 0);          // reciprocal clips high
        send_request(FUNC_DIV, a, b, -1, 0);         // reciprocal clips low
        send_request(FUNC_DIV, a, b, mn, 0);
        send_request(FUNC_NORM, '{1, 0, 0}, b, 0, 0);
        send_request(FUNC_SCALE, '{mn, mn, mn}, b, mn, 0);
        send_request(FUNC_LEN, '{mn, mn, mn}, b, 0, 0);
        send_request(FUNC_LSQ, '{-32'sh0000_8000, 0, 0}, b, 0, 0);
        go_idle();
    endtask

    task automatic test_random(input int n);
        logic signed [31:0] a[3], b[3];
        logic [3:0] f;
        int mode, gap;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 3);
            f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            for (int c = 0; c < 3; c++) begin
                a[c] = rand_word(mode);
                b[c] = rand_word(mode);
            end
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            send_request(f, a, b, ($urandom_range(0, 15) == 0) ? 0 : rand_word(mode), gap);
            if (i == n / 2) begin
                // hold off until the pipe drains
                go_idle();
                while (expected_q.size() != 0) @(posedge i_clk);
            end
        end
        go_idle();
    endtask

    always @(posedge i_clk) begin
        t_vres e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_res_x !== e.rx) begin
                    $error("res_x exp %h got %h", e.rx, o_res_x); errors++;
                end
                if (o_res_y !== e.ry) begin
                    $error("res_y exp %h got %h", e.ry, o_res_y); errors++;
                end
                if (o_res_z !== e.rz) begin
                    $error("res_z exp %h got %h", e.rz, o_res_z); errors++;
                end
                if (o_res_scalar !== e.rs) begin
                    $error("res_scalar exp %h got %h", e.rs, o_res_scalar); errors++;
                end
                if (o_passed_through !== e.pass) begin
                    $error("passed_through exp %b got %b", e.pass, o_passed_through);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1725);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
